### hdl/hic_pkg.sv
// ----------------------------------------------------------------------------
// hic_pkg: shared types and constants of the Hermite inverse-CDF sampler
// Interval store and guide table sizes, queue item layout, sequencer states.
// ----------------------------------------------------------------------------
package hic_pkg;

  localparam int MAX_INTERVALS = 256;
  localparam int GUIDE_LENGTH  = 1024;
  localparam int IDX_W         = $clog2(MAX_INTERVALS);
  localparam int GUIDE_W       = $clog2(GUIDE_LENGTH);
  localparam int SLOT_W        = 10;
  localparam int COUNT_W       = 9;
  localparam int U_W           = 31;
  localparam int CDF_W         = 32;
  localparam int COEF_W        = 48;
  localparam int ACC_W         = 51;
  localparam int QUEUE_DEPTH   = 4;
  localparam int QPTR_W        = $clog2(QUEUE_DEPTH);

  // input selector codes
  localparam logic [1:0] MODE_LOAD_INTERVAL = 2'd0;
  localparam logic [1:0] MODE_LOAD_GUIDE    = 2'd1;
  localparam logic [1:0] MODE_DRAW          = 2'd2;
  localparam logic [1:0] MODE_RESERVED      = 2'd3;

  typedef enum logic [1:0] {
    KIND_LOAD_INTERVAL,
    KIND_LOAD_GUIDE,
    KIND_DRAW
  } kind_t;

  typedef struct packed {
    kind_t                    kind;
    logic [SLOT_W-1:0]        slot;
    logic [U_W-1:0]           u;
    logic [CDF_W-1:0]         cdf_low;
    logic [CDF_W-1:0]         cdf_high;
    logic signed [COEF_W-1:0] c0;
    logic signed [COEF_W-1:0] c1;
    logic signed [COEF_W-1:0] c2;
    logic signed [COEF_W-1:0] c3;
    logic [IDX_W-1:0]         start;
  } item_t;

  typedef struct packed {
    logic [CDF_W-1:0]         hi;
    logic [CDF_W-1:0]         lo;
    logic signed [COEF_W-1:0] c0;
    logic signed [COEF_W-1:0] c1;
    logic signed [COEF_W-1:0] c2;
    logic signed [COEF_W-1:0] c3;
  } interval_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_GUIDE,
    ST_WALK,
    ST_DIV,
    ST_SQUARE,
    ST_CUBE,
    ST_TERM_MUL,
    ST_TERM_ADD,
    ST_OUT
  } state_t;

endpackage

### hdl/hic_front.sv
// ----------------------------------------------------------------------------
// hic_front: input stage
// Accepts stream items, drops ignored ones, registers classified items.
// ----------------------------------------------------------------------------
module hic_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_mode,
  input  logic [311:0]        in_data,
  output logic                item_valid,
  input  logic                item_ready,
  output hic_pkg::item_t      item
);

  logic           keep;
  hic_pkg::item_t decoded;

  // classify: mode three and interval slots beyond the store are dropped
  always_comb begin
    decoded.slot     = in_data[9:0];
    decoded.u        = in_data[40:10];
    decoded.cdf_low  = in_data[72:41];
    decoded.cdf_high = in_data[104:73];
    decoded.c0       = in_data[152:105];
    decoded.c1       = in_data[200:153];
    decoded.c2       = in_data[248:201];
    decoded.c3       = in_data[296:249];
    decoded.start    = in_data[304:297];
    decoded.kind     = hic_pkg::KIND_DRAW;
    keep             = 1'b0;
    case (in_mode)
      hic_pkg::MODE_LOAD_INTERVAL: begin
        decoded.kind = hic_pkg::KIND_LOAD_INTERVAL;
        keep = ({22'd0, in_data[9:0]} < 32'(hic_pkg::MAX_INTERVALS));
      end
      hic_pkg::MODE_LOAD_GUIDE: begin
        decoded.kind = hic_pkg::KIND_LOAD_GUIDE;
        keep = ({22'd0, in_data[9:0]} < 32'(hic_pkg::GUIDE_LENGTH));
      end
      hic_pkg::MODE_DRAW: begin
        decoded.kind = hic_pkg::KIND_DRAW;
        keep = 1'b1;
      end
      default: keep = 1'b0;
    endcase
  end

  assign in_ready = !item_valid || item_ready;

  // hold one classified item until the queue takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid && keep;
    end
    if (in_ready && in_valid) begin
      item <= decoded;
    end
  end

endmodule

### hdl/hic_queue.sv
// ----------------------------------------------------------------------------
// hic_queue: item queue
// Small FIFO between the input stage and the evaluation engine.
// ----------------------------------------------------------------------------
module hic_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  hic_pkg::item_t push_item,
  output logic           pop_valid,
  input  logic           pop_ready,
  output hic_pkg::item_t pop_item
);

  hic_pkg::item_t                   slots [hic_pkg::QUEUE_DEPTH];
  logic [hic_pkg::QPTR_W-1:0]       wr_ptr;
  logic [hic_pkg::QPTR_W-1:0]       rd_ptr;
  logic [hic_pkg::QPTR_W:0]         fill;
  logic                             do_push;
  logic                             do_pop;

  assign push_ready = (fill != (hic_pkg::QPTR_W+1)'(hic_pkg::QUEUE_DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_item   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop) fill <= fill + 1'b1;
      else if (!do_push && do_pop) fill <= fill - 1'b1;
    end
    if (do_push) slots[wr_ptr] <= push_item;
  end

endmodule

### hdl/hic_back.sv
// ----------------------------------------------------------------------------
// hic_back: evaluation engine
// Stores intervals and guide table, walks intervals, divides, evaluates cubic.
// ----------------------------------------------------------------------------
module hic_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [8:0]          cfg_wdata,
  input  logic                item_valid,
  output logic                item_ready,
  input  hic_pkg::item_t      item,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [55:0]         out_data
);

  localparam int IW    = hic_pkg::IDX_W;
  localparam int ACC_W = hic_pkg::ACC_W;

  hic_pkg::interval_t iv_mem [hic_pkg::MAX_INTERVALS];
  logic [IW-1:0]      guide_mem [hic_pkg::GUIDE_LENGTH];

  hic_pkg::state_t    state, state_next;
  logic [8:0]         interval_count;
  logic [IW-1:0]      last_idx;

  hic_pkg::interval_t iv_rd;
  logic [IW-1:0]      guide_rd;
  logic               iv_we;
  logic               guide_we;
  logic [IW-1:0]      iv_raddr;
  logic [IW-1:0]      guide_clamped;

  logic [hic_pkg::U_W-1:0]   u;
  logic [IW-1:0]             idx;
  hic_pkg::interval_t        cur;
  logic [32:0]               rem;
  logic [31:0]               divisor;
  logic [31:0]               quo;
  logic [5:0]                div_cnt;
  logic [32:0]               t, t2, t3;
  logic [1:0]                k;
  logic [63:0]               low_prod;
  logic signed [48:0]        high_prod;
  logic                      p_full;
  logic signed [hic_pkg::COEF_W-1:0] term_c;
  logic signed [hic_pkg::ACC_W-1:0]  acc;

  logic               walk_on;
  logic [32:0]        rem_shift;
  logic [32:0]        rem_sub;
  logic [32:0]        sel_p;
  logic signed [hic_pkg::COEF_W-1:0] sel_c;
  logic [63:0]        sq_prod;
  logic [63:0]        cube_prod;
  logic signed [48:0] term;
  logic signed [hic_pkg::ACC_W-1:0] sat_hi, sat_lo;
  logic [47:0]        sample_sat;

  // clamp the count register to the store size, zero acts as one
  always_comb begin
    if (interval_count == '0) last_idx = '0;
    else if (interval_count > 9'(hic_pkg::MAX_INTERVALS)) last_idx = '1;
    else last_idx = IW'(interval_count - 9'd1);
  end

  assign guide_clamped = (guide_rd > last_idx) ? last_idx : guide_rd;
  assign walk_on       = (idx < last_idx) && (iv_rd.hi < {1'b0, u});

  // control outputs of the sequencer
  always_comb begin
    item_ready = (state == hic_pkg::ST_IDLE);
    iv_we      = (state == hic_pkg::ST_IDLE) && item_valid &&
                 (item.kind == hic_pkg::KIND_LOAD_INTERVAL);
    guide_we   = (state == hic_pkg::ST_IDLE) && item_valid &&
                 (item.kind == hic_pkg::KIND_LOAD_GUIDE);
    case (state)
      hic_pkg::ST_GUIDE: iv_raddr = guide_clamped;
      default:           iv_raddr = idx + 1'b1;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      hic_pkg::ST_IDLE:
        if (item_valid && item.kind == hic_pkg::KIND_DRAW) state_next = hic_pkg::ST_GUIDE;
      hic_pkg::ST_GUIDE: state_next = hic_pkg::ST_WALK;
      hic_pkg::ST_WALK: begin
        if (!walk_on) begin
          if (iv_rd.hi <= iv_rd.lo || {1'b0, u} <= iv_rd.lo || {1'b0, u} >= iv_rd.hi)
            state_next = hic_pkg::ST_SQUARE;
          else
            state_next = hic_pkg::ST_DIV;
        end
      end
      hic_pkg::ST_DIV:
        if (div_cnt == 6'd31) state_next = hic_pkg::ST_SQUARE;
      hic_pkg::ST_SQUARE:   state_next = hic_pkg::ST_CUBE;
      hic_pkg::ST_CUBE:     state_next = hic_pkg::ST_TERM_MUL;
      hic_pkg::ST_TERM_MUL: state_next = hic_pkg::ST_TERM_ADD;
      hic_pkg::ST_TERM_ADD:
        state_next = (k == 2'd3) ? hic_pkg::ST_OUT : hic_pkg::ST_TERM_MUL;
      hic_pkg::ST_OUT:
        if (!out_valid || out_ready) state_next = hic_pkg::ST_IDLE;
      default: state_next = hic_pkg::ST_IDLE;
    endcase
  end

  // restoring divide step, one quotient bit a cycle
  assign rem_shift = {rem[31:0], 1'b0};
  assign rem_sub   = rem_shift - {1'b0, divisor};

  // products for powers of t
  assign sq_prod   = t[31:0] * t[31:0];
  assign cube_prod = t2[31:0] * t[31:0];

  // pick coefficient and power of t for the current term
  always_comb begin
    case (k)
      2'd1:    begin sel_c = cur.c1; sel_p = t;  end
      2'd2:    begin sel_c = cur.c2; sel_p = t2; end
      default: begin sel_c = cur.c3; sel_p = t3; end
    endcase
  end

  // floor(c*p/2^32) = (c>>>32)*p + floor(c_low*p/2^32)
  assign term = high_prod + $signed({17'd0, low_prod[63:32]});

  // saturate the sum to 48 bits
  assign sat_hi = ACC_W'(48'sh7FFF_FFFF_FFFF);
  assign sat_lo = -(hic_pkg::ACC_W'(49'sh0_8000_0000_0000));
  always_comb begin
    if (acc > sat_hi)      sample_sat = 48'h7FFF_FFFF_FFFF;
    else if (acc < sat_lo) sample_sat = 48'h8000_0000_0000;
    else                   sample_sat = acc[47:0];
  end

  // memories: write on load, registered read; guide is addressed by the incoming draw
  always_ff @(posedge clk) begin
    if (iv_we) begin
      iv_mem[item.slot[IW-1:0]] <= '{hi: item.cdf_high, lo: item.cdf_low, c0: item.c0,
                                     c1: item.c1, c2: item.c2, c3: item.c3};
    end
    iv_rd <= iv_mem[iv_raddr];
    if (guide_we) guide_mem[item.slot[hic_pkg::GUIDE_W-1:0]] <= item.start;
    guide_rd <= guide_mem[item.u[hic_pkg::U_W-1 -: hic_pkg::GUIDE_W]];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= hic_pkg::ST_IDLE;
      interval_count <= 9'd1;
      out_valid      <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) interval_count <= cfg_wdata;
      if (state == hic_pkg::ST_OUT && (!out_valid || out_ready)) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      hic_pkg::ST_IDLE: begin
        u <= item.u;
      end
      hic_pkg::ST_GUIDE: begin
        idx <= guide_clamped;
      end
      hic_pkg::ST_WALK: begin
        cur     <= iv_rd;
        rem     <= {1'b0, 32'({1'b0, u}) - iv_rd.lo};
        divisor <= iv_rd.hi - iv_rd.lo;
        div_cnt <= '0;
        if (walk_on) begin
          idx <= idx + 1'b1;
        end else if (iv_rd.hi <= iv_rd.lo || {1'b0, u} <= iv_rd.lo) begin
          t <= 33'd0;
        end else begin
          t <= {1'b1, 32'd0};
        end
      end
      hic_pkg::ST_DIV: begin
        div_cnt <= div_cnt + 1'b1;
        if (!rem_sub[32]) begin
          rem <= rem_sub;
          quo <= {quo[30:0], 1'b1};
          if (div_cnt == 6'd31) t <= {1'b0, quo[30:0], 1'b1};
        end else begin
          rem <= rem_shift;
          quo <= {quo[30:0], 1'b0};
          if (div_cnt == 6'd31) t <= {1'b0, quo[30:0], 1'b0};
        end
      end
      hic_pkg::ST_SQUARE: begin
        t2  <= t[32] ? t : {1'b0, sq_prod[63:32]};
        acc <= ACC_W'(cur.c0);
        k   <= 2'd1;
      end
      hic_pkg::ST_CUBE: begin
        if (t2[32])     t3 <= t;
        else if (t[32]) t3 <= t2;
        else            t3 <= {1'b0, cube_prod[63:32]};
      end
      hic_pkg::ST_TERM_MUL: begin
        p_full    <= sel_p[32];
        term_c    <= sel_c;
        low_prod  <= {16'd0, sel_c[31:0]} * {32'd0, sel_p[31:0]};
        high_prod <= 49'($signed(sel_c[47:32])) * 49'($signed({1'b0, sel_p[31:0]}));
      end
      hic_pkg::ST_TERM_ADD: begin
        if (p_full) acc <= acc + ACC_W'(term_c);
        else        acc <= acc + ACC_W'(term);
        k <= k + 1'b1;
      end
      hic_pkg::ST_OUT: begin
        if (!out_valid || out_ready) out_data <= {idx, sample_sat};
      end
      default: begin
      end
    endcase
  end

endmodule

### hdl/hermite_inverse_cdf_sampler.sv
// ----------------------------------------------------------------------------
// hermite_inverse_cdf_sampler: piecewise cubic Hermite inverse-CDF sampler
// Load items fill the interval store and guide table; draw items give samples.
// ----------------------------------------------------------------------------
// Per draw: input register and queue, then engine states guide lookup, walk, divide,
// square, cube, the term multiply-add loop and output; the division is skipped when
// u is outside the interval or the interval is empty. The engine takes no new item
// until a draw has reached the output register; the 32-step divider and the walk set its pace.
// Reset clears handshake and sequencer state and sets interval_count to 1;
// stored intervals and guide entries keep their contents until written.
module hermite_inverse_cdf_sampler (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [8:0]   cfg_wdata,     // interval_count
  input  logic         s_tvalid,
  output logic         s_tready,
  // slot[9:0], uniform_value[40:10], cdf_low[72:41], cdf_high[104:73],
  // coef_zero[152:105], coef_one[200:153], coef_two[248:201],
  // coef_three[296:249], start_interval[304:297], zero fill above
  input  logic [311:0] s_tdata,
  input  logic [1:0]   s_tuser,       // mode[1:0]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [55:0]  m_tdata        // sample[47:0], interval_used[55:48]
);

  logic           f_valid, f_ready;
  hic_pkg::item_t f_item;
  logic           q_valid, q_ready;
  hic_pkg::item_t q_item;

  hic_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_mode    (s_tuser),
    .in_data    (s_tdata),
    .item_valid (f_valid),
    .item_ready (f_ready),
    .item       (f_item)
  );

  hic_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_item  (f_item),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_item   (q_item)
  );

  hic_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .item_valid (q_valid),
    .item_ready (q_ready),
    .item       (q_item),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_data   (m_tdata)
  );

endmodule
